[hdl/srt_pkg.sv]
// Shared types, constants and helpers for the service registry table.
package srt_pkg;

   localparam int ENTRIES    = 256;
   localparam int NAME_BYTES = 32;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int CNT_W      = $clog2(ENTRIES + 1);
   localparam int NAME_W     = 256;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_INVAL    = 3'd1,
      ST_EXISTS   = 3'd2,
      ST_NOSPACE  = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] name_word0;
      logic [63:0] name_word1;
      logic [63:0] name_word2;
      logic [63:0] name_word3;
      logic [31:0] version;
      logic [31:0] svc_id;
      logic [31:0] xport_flags;
      logic [31:0] endpoint;
      logic        endpoint_valid;
      logic        exact_mode;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] found_svc_id;
      logic [31:0] found_version;
      logic [31:0] found_flags;
      logic [31:0] found_endpoint;
   } rsp_type;

   // one table entry as it travels along the cell chain
   typedef struct packed {
      logic              used;
      logic [NAME_W-1:0] name;
      logic [31:0]       version;
      logic [31:0]       svc_id;
      logic [31:0]       flags;
      logic [31:0]       endpoint;
   } entry_type;

   // command from the controller to each cell; rotate is the same for every cell
   typedef struct packed {
      logic              rotate;
      logic              write;
      logic              clear;
   } cell_ctl_type;

   function automatic logic [NAME_W-1:0] normalize(input logic [NAME_W-1:0] raw);
      logic [NAME_W-1:0] key;
      logic              live;
      key  = '0;
      live = 1'b1;
      for (int b = 0; b < NAME_BYTES - 1; b++) begin
         if (raw[8*b +: 8] == 8'd0) live = 1'b0;
         if (live) key[8*b +: 8] = raw[8*b +: 8];
      end
      return key;
   endfunction

endpackage

[hdl/srt_cell.sv]
// One table cell: holds an entry and passes it to its neighbor on rotate.
module srt_cell
   import srt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  entry_type    prev_entry,
   input  entry_type    wr_entry,
   output entry_type    entry
);
   entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.rotate) begin
         entry_in = prev_entry;
      end
      if (ctl.write) begin
         entry_in = wr_entry;
      end
      if (ctl.clear) begin
         entry_in.used = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         entry_ff.used <= 1'b0;
      end
   end

   assign entry = entry_ff;
endmodule

[hdl/service_registry_table_core.sv]
// Top level of the service registry table: controller and rotating cell chain.
//
//   channel | direction | handshake           | word
//   req     | in        | req_valid/req_stall | req_word (req_type)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_word (rsp_type)
//
// An item is latched; then the cell ring rotates one full turn past the head
// cell, and the result is finished and then presented. Rate is set by the single
// head comparator.
// Reset clears every cell's used bit at once; a result held under rsp_stall
// blocks the next request until taken.
module service_registry_table_core
   import srt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_DONE = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [NAME_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              hit_ff, hit_in, dup_ff, dup_in, free_ff, free_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   entry_type         best_ff, best_in;
   rsp_type           rsp_ff, rsp_in;
   logic              write_ff, write_in;
   logic              any_ff, any_in;

   entry_type    chain [ENTRIES];
   entry_type    wr_entry;
   cell_ctl_type ctl [ENTRIES];
   entry_type    head;
   logic         match, inval;

   assign head  = chain[0];
   assign match = head.used && head.name == key_ff;
   assign inval = req_ff.opcode == OP_NONE || key_ff[7:0] == 8'd0;

   always_comb begin
      wr_entry.used     = 1'b1;
      wr_entry.name     = key_ff;
      wr_entry.version  = req_ff.version;
      wr_entry.svc_id   = req_ff.svc_id;
      wr_entry.flags    = req_ff.xport_flags;
      wr_entry.endpoint = req_ff.endpoint;
   end

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      always_comb begin
         ctl[g].rotate  = state_ff == S_SCAN;
         ctl[g].write   = write_ff && free_idx_ff == IDX_W'(g);
         ctl[g].clear   = state_ff == S_SCAN && g == ENTRIES - 1
                          && req_ff.opcode == OP_REMOVE && !inval && match;
      end
      srt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl[g]),
         .prev_entry (chain[(g + 1) % ENTRIES]),
         .wr_entry   (wr_entry),
         .entry      (chain[g])
      );
   end

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      key_in      = key_ff;
      cnt_in      = cnt_ff;
      hit_in      = hit_ff;
      dup_in      = dup_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      best_in     = best_ff;
      rsp_in      = rsp_ff;
      write_in    = 1'b0;
      any_in      = any_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_word;
               key_in   = normalize({req_word.name_word3, req_word.name_word2,
                                     req_word.name_word1, req_word.name_word0});
               cnt_in   = '0;
               hit_in   = 1'b0;
               dup_in   = 1'b0;
               free_in  = 1'b0;
               any_in   = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // head holds the entry of index cnt
            if (match && head.version == req_ff.version) dup_in = 1'b1;
            if (!head.used && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = cnt_ff[IDX_W-1:0];
            end
            if (match) any_in = 1'b1;
            if (match) begin
               if (req_ff.exact_mode) begin
                  if (head.version == req_ff.version && !hit_ff) begin
                     hit_in  = 1'b1;
                     best_in = head;
                  end
               end else if (head.version >= req_ff.version &&
                            (!hit_ff || head.version > best_ff.version)) begin
                  hit_in  = 1'b1;
                  best_in = head;
               end
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ENTRIES - 1)) state_in = S_DONE;
         end
         S_DONE: begin
            rsp_in = '0;
            priority if (inval) begin
               rsp_in.status = ST_INVAL;
            end else if (req_ff.opcode == OP_ADD) begin
               priority if (!req_ff.endpoint_valid) rsp_in.status = ST_INVAL;
               else if (dup_ff)                 rsp_in.status = ST_EXISTS;
               else if (!free_ff)               rsp_in.status = ST_NOSPACE;
               else begin
                  rsp_in.status = ST_OK;
                  write_in      = 1'b1;
               end
            end else if (req_ff.opcode == OP_LOOKUP) begin
               if (hit_ff) begin
                  rsp_in.status         = ST_OK;
                  rsp_in.found_svc_id   = best_ff.svc_id;
                  rsp_in.found_version  = best_ff.version;
                  rsp_in.found_flags    = best_ff.flags;
                  rsp_in.found_endpoint = best_ff.endpoint;
               end else begin
                  rsp_in.status = ST_NOTFOUND;
               end
            end else begin
               rsp_in.status = any_ff ? ST_OK : ST_NOTFOUND;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      key_ff      <= key_in;
      cnt_ff      <= cnt_in;
      hit_ff      <= hit_in;
      dup_ff      <= dup_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      best_ff     <= best_in;
      rsp_ff      <= rsp_in;
      any_ff      <= any_in;
      if (reset) begin
         state_ff <= S_IDLE;
         write_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         write_ff <= write_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_OUT;
   assign rsp_word  = rsp_ff;

   a_write_after_done: assert property (@(posedge clock) disable iff (reset)
      write_ff |-> $past(state_ff) == S_DONE && state_ff == S_OUT)
      else $error("table write outside finish step");
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while result pending");
   a_scan_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |-> cnt_ff == CNT_W'(ENTRIES))
      else $error("scan did not cover every entry");
endmodule
